// ----- hw/rtl/frp_pkg.sv -----
// Shared types, register codes and constants for the frame rotate block.
`timescale 1ns / 1ps
`default_nettype none
package frp_pkg;

    // default sizes handed to the top level parameters
    localparam int FRP_MAX_WIDTH    = 64;
    localparam int FRP_MAX_HEIGHT   = 64;
    localparam int FRP_CHANNEL_BITS = 8;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int SIZE_W     = 7;
    localparam int ROT_W      = 2;
    localparam int OP_W       = 2;
    localparam int MAXV_W     = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POINT_OP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_VAL  = 3'd4;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 7'd64;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 7'd64;
    localparam logic [MAXV_W-1:0] MAXV_RST   = 8'd255;

    localparam logic [ROT_W-1:0] ROT_NONE  = 2'd0;
    localparam logic [ROT_W-1:0] ROT_LEFT  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_RIGHT = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE     = 2'd0;
    localparam logic [OP_W-1:0] OP_GRAY     = 2'd1;
    localparam logic [OP_W-1:0] OP_MONO     = 2'd2;
    localparam logic [OP_W-1:0] OP_NEGATIVE = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // BT.601 luma weights, 16-bit fixed point
    localparam int GRAY_W      = 16;
    localparam logic [GRAY_W-1:0] GRAY_KR = 16'd19595;
    localparam logic [GRAY_W-1:0] GRAY_KG = 16'd38470;
    localparam logic [GRAY_W-1:0] GRAY_KB = 16'd7471;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_INDEX,
        ST_ADDR,
        ST_READ,
        ST_POINT,
        ST_EMIT
    } t_frp_state;

    typedef struct packed {
        logic capture;
        logic store;
        logic restart;
        logic mul;
        logic addr;
        logic read;
        logic point;
        logic emit;
    } t_frp_cmd;

    typedef struct packed {
        logic is_fetch;
        logic full;
    } t_frp_status;

endpackage
`default_nettype wire

// ----- hw/rtl/frp_ctrl.sv -----
// Sequencer for load and fetch requests of the frame rotate block.
`timescale 1ns / 1ps
`default_nettype none
module frp_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  frp_pkg::t_frp_status i_status,
    output frp_pkg::t_frp_cmd    o_cmd,
    output logic                 busy
);
    import frp_pkg::*;

    t_frp_state r_state;
    t_frp_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // a fetch runs only against a complete frame
                if (i_status.is_fetch && i_status.full) begin
                    n_state = ST_INDEX;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_INDEX: n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_READ;
            ST_READ:  n_state = ST_POINT;
            ST_POINT: n_state = ST_EMIT;
            ST_EMIT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ST_CHECK: begin
                o_cmd.store   = !i_status.is_fetch && !i_status.full;
                o_cmd.restart = i_status.is_fetch && i_status.full;
            end
            ST_INDEX: o_cmd.mul   = 1'b1;
            ST_ADDR:  o_cmd.addr  = 1'b1;
            ST_READ:  o_cmd.read  = 1'b1;
            ST_POINT: o_cmd.point = 1'b1;
            ST_EMIT:  o_cmd.emit  = 1'b1;
            default:  busy        = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/frp_dp.sv -----
// Datapath: configuration, frame store, read-order counters and point operation.
`timescale 1ns / 1ps
`default_nettype none
module frp_dp #(
    parameter int MAX_WIDTH    = frp_pkg::FRP_MAX_WIDTH,
    parameter int MAX_HEIGHT   = frp_pkg::FRP_MAX_HEIGHT,
    parameter int CHANNEL_BITS = frp_pkg::FRP_CHANNEL_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [frp_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [frp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  frp_pkg::t_frp_cmd                i_cmd,
    output frp_pkg::t_frp_status             o_status,
    input  wire                              i_kind,
    input  wire  [CHANNEL_BITS-1:0]          i_red_in,
    input  wire  [CHANNEL_BITS-1:0]          i_green_in,
    input  wire  [CHANNEL_BITS-1:0]          i_blue_in,
    output logic                             o_valid,
    output logic [CHANNEL_BITS-1:0]          o_red_out,
    output logic [CHANNEL_BITS-1:0]          o_green_out,
    output logic [CHANNEL_BITS-1:0]          o_blue_out,
    output logic                             o_frame_end
);
    import frp_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOT_W   = 2 * SIZE_W;
    localparam int IDX_W   = (TOT_W + 1 > CNT_W) ? TOT_W + 1 : CNT_W;
    localparam int CB      = CHANNEL_BITS;
    localparam int PX_W    = 3 * CB;
    localparam int GP_W    = CB + GRAY_W;
    localparam int GS_W    = GP_W + 2;
    localparam int NEG_W   = (CB > MAXV_W) ? CB : MAXV_W;

    // configuration registers
    logic [SIZE_W-1:0] r_cfg_width;
    logic [SIZE_W-1:0] r_cfg_height;
    logic [ROT_W-1:0]  r_cfg_rot;
    logic [OP_W-1:0]   r_cfg_op;
    logic [MAXV_W-1:0] r_cfg_maxv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_cfg_rot    <= ROT_NONE;
            r_cfg_op     <= OP_NONE;
            r_cfg_maxv   <= MAXV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH:    r_cfg_width  <= i_cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT:   r_cfg_height <= i_cfg_wdata[SIZE_W-1:0];
                REG_ROTATION: r_cfg_rot    <= i_cfg_wdata[ROT_W-1:0];
                REG_POINT_OP: r_cfg_op     <= i_cfg_wdata[OP_W-1:0];
                REG_MAX_VAL:  r_cfg_maxv   <= i_cfg_wdata[MAXV_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes and read order
    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] h_size;
    logic [ROT_W-1:0]  rot;
    logic [SIZE_W-1:0] outer_bound;
    logic [SIZE_W-1:0] inner_bound;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_size = SIZE_W'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_size = SIZE_W'(MAX_WIDTH);
        end else begin
            w_size = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h_size = SIZE_W'(1);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h_size = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_size = r_cfg_height;
        end
        rot = (r_cfg_rot == ROT_LEFT || r_cfg_rot == ROT_RIGHT) ? r_cfg_rot : ROT_NONE;
        outer_bound = (rot == ROT_NONE) ? h_size : w_size;
        inner_bound = (rot == ROT_NONE) ? w_size : h_size;
    end

    // pixel count, registered off the multiplier
    logic [TOT_W-1:0] r_total;
    always_ff @(posedge i_clk) begin
        r_total <= TOT_W'(w_size) * TOT_W'(h_size);
    end

    // request capture
    logic          r_kind;
    logic [PX_W-1:0] r_px_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_px_in <= {i_red_in, i_green_in, i_blue_in};
        end
    end

    logic [CNT_W-1:0]  r_load_cnt;
    logic [SIZE_W-1:0] r_outer;
    logic [SIZE_W-1:0] r_inner;
    logic              r_last;

    assign o_status.is_fetch = (r_kind == KIND_FETCH);
    assign o_status.full     = IDX_W'(r_load_cnt) >= IDX_W'(r_total);

    // read address: one product, then the order-specific sum
    logic [TOT_W-1:0]  r_prod;
    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= TOT_W'(rot == ROT_NONE ? r_outer : r_inner) * TOT_W'(w_size);
        end
    end

    always_comb begin
        case (rot)
            ROT_LEFT:  idx = IDX_W'(w_size) - IDX_W'(1) + IDX_W'(r_prod)
                             - IDX_W'(r_outer);
            ROT_RIGHT: idx = IDX_W'(r_total) - IDX_W'(w_size) - IDX_W'(r_prod)
                             + IDX_W'(r_outer);
            default:   idx = IDX_W'(r_prod) + IDX_W'(r_inner);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_addr <= (idx >= IDX_W'(DEPTH)) ? '0 : idx[ADDR_W-1:0];
            r_last <= (r_outer == outer_bound - SIZE_W'(1)) &&
                      (r_inner == inner_bound - SIZE_W'(1));
        end
    end

    // load count and read-order counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_outer    <= '0;
            r_inner    <= '0;
        end else begin
            if (i_cmd.store) begin
                r_load_cnt <= r_load_cnt + CNT_W'(1);
            end
            if (i_cmd.restart) begin
                // size or rotation may have changed since the last fetch
                if (r_outer >= outer_bound) begin
                    r_outer <= '0;
                end
                if (r_inner >= inner_bound) begin
                    r_inner <= '0;
                end
            end
            if (i_cmd.emit) begin
                if (r_last) begin
                    r_outer    <= '0;
                    r_inner    <= '0;
                    r_load_cnt <= '0;
                end else if (SIZE_W'(r_inner + SIZE_W'(1)) >= inner_bound) begin
                    r_inner <= '0;
                    r_outer <= r_outer + SIZE_W'(1);
                end else begin
                    r_inner <= r_inner + SIZE_W'(1);
                end
            end
        end
    end

    // frame store
    logic [PX_W-1:0] mem [DEPTH];
    logic [PX_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_load_cnt[ADDR_W-1:0]] <= r_px_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd <= mem[r_addr];
        end
    end

    logic [CB-1:0] rd_r;
    logic [CB-1:0] rd_g;
    logic [CB-1:0] rd_b;
    assign rd_r = r_rd[2*CB +: CB];
    assign rd_g = r_rd[CB +: CB];
    assign rd_b = r_rd[0 +: CB];

    // luma products, registered before the sum
    logic [GP_W-1:0] r_gr;
    logic [GP_W-1:0] r_gg;
    logic [GP_W-1:0] r_gb;
    always_ff @(posedge i_clk) begin
        if (i_cmd.point) begin
            r_gr <= GP_W'(rd_r) * GP_W'(GRAY_KR);
            r_gg <= GP_W'(rd_g) * GP_W'(GRAY_KG);
            r_gb <= GP_W'(rd_b) * GP_W'(GRAY_KB);
        end
    end

    logic [GS_W-1:0]  gray_sum;
    logic [CB-1:0]    gray;
    logic [CB-1:0]    mono;
    logic [CB-1:0]    res_r;
    logic [CB-1:0]    res_g;
    logic [CB-1:0]    res_b;

    function automatic logic [CB-1:0] negate(input logic [CB-1:0] c,
                                             input logic [MAXV_W-1:0] maxv);
        logic [NEG_W-1:0] cx;
        logic [NEG_W-1:0] mx;
        logic [NEG_W-1:0] diff;
        cx   = NEG_W'(c);
        mx   = NEG_W'(maxv);
        diff = mx - cx;
        return (cx > mx) ? '0 : diff[CB-1:0];
    endfunction

    always_comb begin
        gray_sum = GS_W'(r_gr) + GS_W'(r_gg) + GS_W'(r_gb);
        gray     = gray_sum[GRAY_W +: CB];
        mono     = CB'(|r_rd);
        case (r_cfg_op)
            OP_GRAY: begin
                res_r = gray;
                res_g = gray;
                res_b = gray;
            end
            OP_MONO: begin
                res_r = mono;
                res_g = mono;
                res_b = mono;
            end
            OP_NEGATIVE: begin
                res_r = negate(rd_r, r_cfg_maxv);
                res_g = negate(rd_g, r_cfg_maxv);
                res_b = negate(rd_b, r_cfg_maxv);
            end
            default: begin
                res_r = rd_r;
                res_g = rd_g;
                res_b = rd_b;
            end
        endcase
    end

    // result register, strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_red_out   <= res_r;
            o_green_out <= res_g;
            o_blue_out  <= res_b;
            o_frame_end <= r_last;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/frame_rotate_point_op_top.sv -----
// Top level: frame store with rotated readout and per-pixel point operation.
// A load request occupies the accept and check states; start is taken again
// on the next cycle. A fetch steps through the check, index (address
// multiply), address, store read, point (luma products) and emit states;
// emit registers the result onto o_valid; a fetch before the frame is full
// ends after check. The receiver cannot stall. Synchronous active-low reset
// clears the counters and config registers to defaults; store contents stay.
`timescale 1ns / 1ps
`default_nettype none
module frame_rotate_point_op_top #(
    parameter int MAX_WIDTH    = frp_pkg::FRP_MAX_WIDTH,
    parameter int MAX_HEIGHT   = frp_pkg::FRP_MAX_HEIGHT,
    parameter int CHANNEL_BITS = frp_pkg::FRP_CHANNEL_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [frp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire  [frp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire                             start,
    output logic                            busy,
    input  wire                             i_kind,
    input  wire  [CHANNEL_BITS-1:0]         i_red_in,
    input  wire  [CHANNEL_BITS-1:0]         i_green_in,
    input  wire  [CHANNEL_BITS-1:0]         i_blue_in,
    output logic                            o_valid,
    output logic [CHANNEL_BITS-1:0]         o_red_out,
    output logic [CHANNEL_BITS-1:0]         o_green_out,
    output logic [CHANNEL_BITS-1:0]         o_blue_out,
    output logic                            o_frame_end
);
    import frp_pkg::*;

    t_frp_cmd    cmd;
    t_frp_status status;

    frp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    frp_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_kind      (i_kind),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire
